// ===== rtl/ismf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismf_pkg
// Shared types and codes for the Metropolis spin-flip block: word layouts,
// mode and register codes, controller-to-datapath command and status.
// ----------------------------------------------------------------------------
package ismf_pkg;

    localparam int SIDE_W    = 7;
    localparam int THR_W     = 33;
    localparam int RND_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_ONE    = 33'h1_0000_0000;

    // Operation codes carried in the input tuser
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_FLIP = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_M8 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_M4 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_P4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR_P8 = 3'd5;

    // Magnetization change codes (signed 3 bit)
    localparam logic [2:0] MAG_UP   = 3'b010;
    localparam logic [2:0] MAG_DOWN = 3'b110;

    // Input word, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]       pad;
        logic [RND_W-1:0] random_fraction;
        logic             spin_value;
        logic [5:0]       col;
        logic [5:0]       row;
    } ismf_in_t;

    // Result word, lowest field in the lowest bits
    typedef struct packed {
        logic       bad_coordinate;
        logic [2:0] mag_change;
        logic [4:0] energy_gap;
        logic       site_spin;
        logic       accepted;
    } ismf_res_t;

    // Which pair of lattice addresses the two read ports carry
    typedef enum logic [1:0] {
        PH_A,   // centre, row plus one
        PH_B,   // row minus one, column plus one
        PH_C    // column minus one
    } rd_phase_t;

    typedef struct packed {
        logic      latch;
        rd_phase_t phase;
        logic      cap_a;
        logic      cap_b;
        logic      cap_c;
        logic      finish;
    } ismf_cmd_t;

    typedef struct packed {
        logic skip_reads;
        logic is_read;
        logic out_free;
    } ismf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ismf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismf_ctrl
// Sequencer: takes one word, walks the lattice reads, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
module ismf_ctrl
    import ismf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire ismf_stat_t stat,
    output ismf_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_CAP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = PH_A;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cmd.phase  = PH_A;
                state_next = stat.skip_reads ? S_FINISH : S_RD_B;
            end
            S_RD_B:
            begin
                cmd.phase  = PH_B;
                cmd.cap_a  = 1'b1;
                state_next = stat.is_read ? S_FINISH : S_RD_C;
            end
            S_RD_C:
            begin
                cmd.phase  = PH_C;
                cmd.cap_b  = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_c  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register can take the result
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ismf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismf_dp
// Datapath: configuration registers, lattice memory with two read ports,
// neighbor addressing with wrap, acceptance test and output register.
// ----------------------------------------------------------------------------
module ismf_dp
    import ismf_pkg::*;
#(
    parameter int MAX_SIDE = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data,
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire ismf_cmd_t            cmd,
    output ismf_stat_t                stat,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int SW    = (NW > SIDE_W) ? NW : SIDE_W;

    function automatic logic [AW-1:0] site_addr(input logic [SW-1:0] rr,
                                                input logic [SW-1:0] cc);
        return AW'(rr) * AW'(MAX_SIDE) + AW'(cc);
    endfunction

    // Configuration
    logic [SIDE_W-1:0] side_reg;
    logic [THR_W-1:0]  thr_reg [5];
    logic [THR_W-1:0]  thr_sat;

    assign thr_sat = (cfg_data > THR_ONE) ? THR_ONE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            for (int i = 0; i < 5; i++)
            begin
                thr_reg[i] <= THR_ONE;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIDE:   side_reg   <= cfg_data[SIDE_W-1:0];
                REG_THR_M8: thr_reg[0] <= thr_sat;
                REG_THR_M4: thr_reg[1] <= thr_sat;
                REG_THR_Z:  thr_reg[2] <= thr_sat;
                REG_THR_P4: thr_reg[3] <= thr_sat;
                REG_THR_P8: thr_reg[4] <= thr_sat;
                default:    ;
            endcase
        end
    end

    // Latched word
    ismf_in_t         in_word;
    logic [1:0]       mode_reg;
    logic [5:0]       row_reg;
    logic [5:0]       col_reg;
    logic             sv_reg;
    logic [RND_W-1:0] rnd_reg;

    assign in_word = s_tdata;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= s_tuser;
            row_reg  <= in_word.row;
            col_reg  <= in_word.col;
            sv_reg   <= in_word.spin_value;
            rnd_reg  <= in_word.random_fraction;
        end
    end

    // Side clamp, coordinate check, wrapped neighbors
    logic [SW-1:0] side_w;
    logic [SW-1:0] n_side;
    logic [SW-1:0] r;
    logic [SW-1:0] c;
    logic [SW-1:0] rp;
    logic [SW-1:0] rm;
    logic [SW-1:0] cp;
    logic [SW-1:0] cm;
    logic          bad;

    assign side_w = SW'(side_reg);
    assign r      = SW'(row_reg);
    assign c      = SW'(col_reg);

    always_comb
    begin
        if (side_w < SW'(2))
        begin
            n_side = SW'(2);
        end
        else if (side_w > SW'(MAX_SIDE))
        begin
            n_side = SW'(MAX_SIDE);
        end
        else
        begin
            n_side = side_w;
        end
    end

    assign bad = (r >= n_side) || (c >= n_side);
    assign rp  = (r + SW'(1) == n_side) ? '0 : r + SW'(1);
    assign rm  = (r == '0) ? n_side - SW'(1) : r - SW'(1);
    assign cp  = (c + SW'(1) == n_side) ? '0 : c + SW'(1);
    assign cm  = (c == '0) ? n_side - SW'(1) : c - SW'(1);

    // Lattice memory: one write port, two registered read ports
    logic          lattice_mem [DEPTH];
    logic [AW-1:0] ra0;
    logic [AW-1:0] ra1;
    logic [AW-1:0] center_addr;
    logic          rd0_reg;
    logic          rd1_reg;
    logic          we;
    logic          wdata;

    assign center_addr = site_addr(r, c);

    always_comb
    begin
        case (cmd.phase)
            PH_A:
            begin
                ra0 = center_addr;
                ra1 = site_addr(rp, c);
            end
            PH_B:
            begin
                ra0 = site_addr(rm, c);
                ra1 = site_addr(r, cp);
            end
            default:
            begin
                ra0 = site_addr(r, cm);
                ra1 = site_addr(r, cm);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            lattice_mem[center_addr] <= wdata;
        end
        rd0_reg <= lattice_mem[ra0];
        rd1_reg <= lattice_mem[ra1];
    end

    // Captured spins
    logic s_center;
    logic s_rp;
    logic s_rm;
    logic s_cp;
    logic s_cm;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            s_center <= rd0_reg;
            s_rp     <= rd1_reg;
        end
        if (cmd.cap_b)
        begin
            s_rm <= rd0_reg;
            s_cp <= rd1_reg;
        end
        if (cmd.cap_c)
        begin
            s_cm <= rd0_reg;
        end
    end

    // Gap: count of up neighbors k gives index k for an up centre, 4-k else
    logic [2:0] up_count;
    logic [2:0] gap_sel;
    logic [5:0] gap_full;
    logic       acc;
    logic       new_spin;

    assign up_count = {2'b00, s_rp} + {2'b00, s_rm} + {2'b00, s_cp} + {2'b00, s_cm};
    assign gap_sel  = s_center ? up_count : 3'd4 - up_count;
    assign gap_full = {1'b0, gap_sel, 2'b00} - 6'd8;
    assign acc      = ({1'b0, rnd_reg} <= thr_reg[gap_sel]);
    assign new_spin = acc ? ~s_center : s_center;

    // Result and lattice write-back
    ismf_res_t res;

    always_comb
    begin
        res = '0;
        if (mode_reg != MODE_NONE)
        begin
            if (bad)
            begin
                res.bad_coordinate = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_LOAD: res.site_spin = sv_reg;
                    MODE_READ: res.site_spin = s_center;
                    MODE_FLIP:
                    begin
                        res.accepted   = acc;
                        res.site_spin  = new_spin;
                        res.energy_gap = gap_full[4:0];
                        if (acc)
                        begin
                            res.mag_change = new_spin ? MAG_UP : MAG_DOWN;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign we    = cmd.finish && !bad &&
                   ((mode_reg == MODE_LOAD) || ((mode_reg == MODE_FLIP) && acc));
    assign wdata = (mode_reg == MODE_LOAD) ? sv_reg : new_spin;

    // Output register
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata_reg <= OUT_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.skip_reads = bad || (mode_reg == MODE_LOAD) || (mode_reg == MODE_NONE);
    assign stat.is_read    = (mode_reg == MODE_READ);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

// ===== rtl/ising_metropolis_spin_flip_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_top
// Metropolis single-spin-flip engine for one square 2D Ising lattice.
//
// Usage:
//   Input words on s_* carry an operation in s_tuser (load, read, flip) and
//   the site, load spin and random fraction in s_tdata. Each word returns
//   exactly one result word on m_*, in order.
//   Configuration writes on cfg_* set the side length and the five Q1.32
//   thresholds; cfg_ready is always high. Write only while the block is idle.
//   Load every site in use before issuing flips.
// Timing:
//   One word at a time. After acceptance a load, bad coordinate or unused
//   code goes from S_RD_A to S_FINISH, a read adds S_RD_B, and a flip adds
//   S_RD_B, S_RD_C and S_CAP; the next word is taken in S_IDLE. The flip
//   path is set by the memory's two read ports: five spins over three reads.
// Reset:
//   Side 64, all thresholds 1.0, output empty. Lattice contents are unknown
//   until written; no clearing pass.
// Stall:
//   One output register; with it full and m_tready low the sequencer holds
//   its finished result and takes no new word.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_flip_top
    import ismf_pkg::*;
#(
    parameter int MAX_SIDE = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,  // row[5:0], col[11:6], spin_value[12],
                                                // random_fraction[44:13], zero pad
    input  wire logic [1:0]           s_tuser,  // mode[1:0]
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata   // accepted[0], site_spin[1],
                                                // energy_gap[6:2], mag_change[9:7],
                                                // bad_coordinate[10], zero pad
);

    ismf_cmd_t  cmd;
    ismf_stat_t stat;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    // Sequencer
    ismf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Lattice, registers and result path
    ismf_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== bench/tb_ising_metropolis_spin_flip_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ising_metropolis_spin_flip_top
// Self-checking bench for the Metropolis spin-flip block. Words go in through
// the input stream and every result word is matched in order against a
// lattice predictor kept in the bench. The predictor tracks spins, side
// length and thresholds. Stimulus opens with a directed part on wrap, reset
// thresholds, saturation, equality and bad sites. Then come phases of random
// words under different settings. Reads and flips only ever touch sites that
// have been loaded. Both stream sides idle at random, and one phase holds the
// result side off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_ising_metropolis_spin_flip_top;
    import ismf_pkg::*;

    localparam int LATTICE_SIDE = 64;
    localparam int SITES        = LATTICE_SIDE * LATTICE_SIDE;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 10;
    localparam int WORDS_PER_PHASE = 16;
    localparam int IDLE_PCT     = 7;

    // indexes beyond the last threshold; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // neighbour selectors for the site lookup
    localparam int NB_CENTRE = 0;
    localparam int NB_ROW_UP = 1;
    localparam int NB_ROW_DN = 2;
    localparam int NB_COL_UP = 3;
    localparam int NB_COL_DN = 4;

    // ------------------------------------------------------------------------
    // Lattice predictor and result store
    // ------------------------------------------------------------------------
    class spin_flip_scoreboard;
        bit                 spins   [SITES];
        bit                 written [SITES];
        logic [SIDE_W-1:0]  side_reg;
        logic [THR_W-1:0]   thr [5];
        ismf_res_t          due_q [$];
        int                 mismatches;

        function new();
            side_reg   = SIDE_RESET;
            mismatches = 0;
            foreach (thr[k]) thr[k] = THR_ONE;
            foreach (spins[k])
            begin
                spins[k]   = 1'b0;
                written[k] = 1'b0;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
            if (idx == REG_SIDE)
                side_reg = data[SIDE_W-1:0];
            else if (idx >= REG_THR_M8 && idx <= REG_THR_P8)
                thr[idx - REG_THR_M8] = (data > THR_ONE) ? THR_ONE : data;
        endfunction

        // side actually used for addressing and wrap
        function int span();
            if (side_reg < 2)
                return 2;
            if (side_reg > LATTICE_SIDE)
                return LATTICE_SIDE;
            return int'(side_reg);
        endfunction

        // lattice index of the centre or one of its wrapped neighbours
        function int site_of(int r, int c, int which);
            int n;
            int rr;
            int cc;
            n  = span();
            rr = r;
            cc = c;
            case (which)
                NB_ROW_UP: rr = (r + 1 == n) ? 0 : r + 1;
                NB_ROW_DN: rr = (r == 0) ? n - 1 : r - 1;
                NB_COL_UP: cc = (c + 1 == n) ? 0 : c + 1;
                NB_COL_DN: cc = (c == 0) ? n - 1 : c - 1;
                default:   ;
            endcase
            return rr * LATTICE_SIDE + cc;
        endfunction

        function int gap_at(int r, int c);
            int s;
            int sum;
            s   = spins[site_of(r, c, NB_CENTRE)] ? 1 : -1;
            sum = 0;
            for (int k = NB_ROW_UP; k <= NB_COL_DN; k++)
                sum += spins[site_of(r, c, k)] ? 1 : -1;
            return 2 * s * sum;
        endfunction

        function logic [THR_W-1:0] threshold_at(int r, int c);
            return thr[(gap_at(r, c) + 8) / 4];
        endfunction

        // work out the result of one accepted word and advance the lattice
        function void note_input(logic [1:0] mode, int r, int c, bit sv,
                                 logic [RND_W-1:0] rnd);
            ismf_res_t e;
            int        idx;
            int        gap;
            e   = '0;
            idx = r * LATTICE_SIDE + c;
            if (mode == MODE_NONE)
                ;
            else if (r >= span() || c >= span())
                e.bad_coordinate = 1'b1;
            else if (mode == MODE_LOAD)
            begin
                spins[idx]   = sv;
                written[idx] = 1'b1;
                e.site_spin  = sv;
            end
            else if (mode == MODE_READ)
                e.site_spin = spins[idx];
            else
            begin
                gap          = gap_at(r, c);
                e.energy_gap = 5'(gap);
                if ({1'b0, rnd} <= thr[(gap + 8) / 4])
                begin
                    spins[idx]   = ~spins[idx];
                    e.accepted   = 1'b1;
                    e.mag_change = spins[idx] ? MAG_UP : MAG_DOWN;
                end
                e.site_spin = spins[idx];
            end
            due_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [4:0] want, logic [4:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: %s mismatch, expected %h, got %h", $realtime, name,
                             want, seen);
            end
        endfunction

        function void check_result(ismf_res_t got);
            ismf_res_t want;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result word %h arrived with nothing pending", $realtime,
                             got);
                return;
            end
            want = due_q.pop_front();
            compare_field("accepted", 5'(want.accepted), 5'(got.accepted));
            compare_field("site_spin", 5'(want.site_spin), 5'(got.site_spin));
            compare_field("energy_gap", want.energy_gap, got.energy_gap);
            compare_field("mag_change", 5'(want.mag_change), 5'(got.mag_change));
            compare_field("bad_coordinate", 5'(want.bad_coordinate), 5'(got.bad_coordinate));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;   // row[5:0], col[11:6], spin_value[12],
                                     // random_fraction[44:13], zero pad
    logic [1:0]           s_tuser;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;   // accepted[0], site_spin[1], energy_gap[6:2],
                                     // mag_change[9:7], bad_coordinate[10], zero pad

    ising_metropolis_spin_flip_top #(
        .MAX_SIDE (LATTICE_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    spin_flip_scoreboard sb;
    bit quiet;      // no idling on either side while set
    bit hold_req;   // ask the result side for one long hold-off
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run; the limit is many times the slowest correct run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, then pick the next ready.
    // A hold-off request drops ready for a long stretch counted here.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(ismf_res_t'(m_tdata[$bits(ismf_res_t)-1:0]));
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Input side tasks
    // ------------------------------------------------------------------------

    // Offer one word and hold it until taken; valid stays high afterwards so
    // back-to-back words see no dip unless the next word idles first.
    task automatic send_word(logic [1:0] mode, int r, int c, bit sv,
                             logic [RND_W-1:0] rnd);
        ismf_in_t w;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        w                 = '0;
        w.row             = 6'(r);
        w.col             = 6'(c);
        w.spin_value      = sv;
        w.random_fraction = rnd;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sb.note_input(mode, r, c, sv, rnd);
    endtask

    // Drop valid and let every pending result come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, data);
    endtask

    // Write side and all five thresholds back to back; optionally put junk
    // above the side bits and hit the spare indexes too.
    task automatic configure(logic [SIDE_W-1:0] side, logic [THR_W-1:0] thr_set [5],
                             bit junk);
        logic [THR_W-1:0] side_word;
        side_word = {junk ? 26'($urandom) : 26'd0, side};
        cfg_write(REG_SIDE, side_word);
        for (int k = 0; k < 5; k++)
            cfg_write(CFG_IDX_W'(REG_THR_M8 + k), thr_set[k]);
        if (junk)
        begin
            cfg_write(REG_SPARE_6, {1'b0, $urandom});
            cfg_write(REG_SPARE_7, 33'h1_FFFF_FFFF);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 33'd1;
            2:       return THR_ONE;
            3:       return THR_ONE - 1;
            4:       return 33'h1_FFFF_FFFF;
            5:       return THR_ONE + 1;
            default: return {1'b0, $urandom};
        endcase
    endfunction

    // Fraction for a flip: lean on the threshold edges so both sides of the
    // compare, including equality, get hit often.
    function automatic logic [RND_W-1:0] pick_fraction(logic [THR_W-1:0] t);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return (t >= THR_ONE) ? '1 : t[RND_W-1:0];
            4:       return (t < THR_ONE - 1) ? t[RND_W-1:0] + 1 : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Load whatever part of the site's cross has never been written.
    task automatic load_cross(int r, int c);
        int idx;
        for (int k = NB_CENTRE; k <= NB_COL_DN; k++)
        begin
            idx = sb.site_of(r, c, k);
            if (!sb.written[idx])
                send_word(MODE_LOAD, idx / LATTICE_SIDE, idx % LATTICE_SIDE,
                          1'($urandom), $urandom);
        end
    endtask

    // One random operation; reads and flips load their sites first when
    // needed so no unwritten spin is ever looked at.
    task automatic random_word();
        int         n;
        int         pick;
        int         r;
        int         c;
        logic [1:0] m;
        n    = sb.span();
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, n - 1);
        c    = $urandom_range(0, n - 1);
        if (pick < 8)
            send_word(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                      1'($urandom), $urandom);
        else if (pick < 18 && n < LATTICE_SIDE)
        begin
            case ($urandom_range(0, 2))
                0:       r = $urandom_range(n, 63);
                1:       c = $urandom_range(n, 63);
                default:
                begin
                    r = $urandom_range(n, 63);
                    c = $urandom_range(n, 63);
                end
            endcase
            case ($urandom_range(0, 2))
                0:       m = MODE_LOAD;
                1:       m = MODE_READ;
                default: m = MODE_FLIP;
            endcase
            send_word(m, r, c, 1'($urandom), $urandom);
        end
        else if (pick < 30)
            send_word(MODE_LOAD, r, c, 1'($urandom), $urandom);
        else if (pick < 45)
        begin
            if (!sb.written[r * LATTICE_SIDE + c])
                send_word(MODE_LOAD, r, c, 1'($urandom), $urandom);
            send_word(MODE_READ, r, c, 1'($urandom), $urandom);
        end
        else
        begin
            load_cross(r, c);
            send_word(MODE_FLIP, r, c, 1'($urandom), pick_fraction(sb.threshold_at(r, c)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [SIDE_W-1:0] side_plan [PHASES];
        logic [THR_W-1:0]  thr_set [5];
        int                n;
        int                fails;

        sb        = new();
        quiet     = 1'b0;
        hold_req  = 1'b0;
        side_plan = '{7'd2, 7'd5, 7'd0, 7'd8, 7'd64, 7'd4, 7'd127, 7'd16, 7'd1, 7'd3};
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SIDE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= MODE_LOAD;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: side 64, every threshold 1.0. Build a cross at the
        // corner so the flip wraps on both axes, and touch the far corner.
        send_word(MODE_LOAD, 0, 0, 1'b1, 32'h0);
        send_word(MODE_LOAD, 1, 0, 1'b0, 32'hFFFF_FFFF);
        send_word(MODE_LOAD, 63, 0, 1'b1, 32'h0);
        send_word(MODE_LOAD, 0, 1, 1'b0, 32'h0);
        send_word(MODE_LOAD, 0, 63, 1'b1, 32'h0);
        send_word(MODE_READ, 0, 0, 1'b0, 32'h0);
        send_word(MODE_FLIP, 0, 0, 1'b1, 32'hFFFF_FFFF);  // 1.0 takes anything
        send_word(MODE_READ, 0, 0, 1'b0, 32'h0);
        send_word(MODE_LOAD, 63, 63, 1'b1, 32'h0);
        send_word(MODE_READ, 63, 63, 1'b0, 32'h0);
        send_word(MODE_NONE, 63, 63, 1'b1, 32'hFFFF_FFFF);

        // Side 3 with edge thresholds: gap -8 never unless the fraction is
        // zero, gap +8 saturated above one. Spare indexes get written here.
        drain();
        thr_set = '{33'd0, 33'd1, THR_ONE, 33'h0_8000_0000, 33'h1_FFFF_FFFF};
        configure(7'd3, thr_set, 1'b1);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_word(MODE_LOAD, r, c, 1'b1, $urandom);
        send_word(MODE_FLIP, 1, 1, 1'b0, 32'hFFFF_FFFF);  // aligned: gap +8
        send_word(MODE_FLIP, 1, 1, 1'b0, 32'h0000_0001);  // now gap -8, rejected
        send_word(MODE_FLIP, 1, 1, 1'b0, 32'h0000_0000);  // equal to zero threshold
        send_word(MODE_LOAD, 3, 0, 1'b1, 32'h0);
        send_word(MODE_READ, 0, 3, 1'b0, 32'h0);
        send_word(MODE_FLIP, 63, 63, 1'b1, 32'hFFFF_FFFF);
        send_word(MODE_NONE, 3, 3, 1'b0, 32'h0);

        // Random phases, each under its own side and thresholds. One phase
        // runs with no idling at all; another holds the result side off.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            quiet = (p == 6);
            foreach (thr_set[k]) thr_set[k] = pick_threshold();
            configure(side_plan[p], thr_set, 1'(p % 2));
            n = sb.span();
            if (n <= 8)
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        send_word(MODE_LOAD, r, c, 1'($urandom), $urandom);
            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (p == 4 && i == 6)
                    hold_req = 1'b1;
                random_word();
            end
        end

        drain();
        quiet = 1'b0;
        repeat (10) @(posedge clk);
        fails = sb.mismatches + sb.pending();
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ismf_pkg.sv
rtl/ismf_ctrl.sv
rtl/ismf_dp.sv
rtl/ising_metropolis_spin_flip_top.sv
bench/tb_ising_metropolis_spin_flip_top.sv
